// File: src/pmtu_pkg.sv
// -----------------------------------------------------------------------------
// Path MTU report convergence: shared types and constants
// Register indexes, status codes, reset values and the state/result structs.
// -----------------------------------------------------------------------------
package pmtu_pkg;

   localparam int MtuWidth   = 16;
   localparam int WaitWidth  = 16;
   localparam int CfgWaitW   = 15;
   localparam int TypeWidth  = 8;
   localparam int CountWidth = 8;
   localparam int CsrAddrW   = 2;
   localparam int CsrDataW   = 15;

   localparam logic [CountWidth-1:0] RepeatMax = '1;

   // configuration register indexes
   localparam logic [CsrAddrW-1:0] CSR_MTU_PACKET_TYPE  = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_REPEAT_THRESHOLD = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_INITIAL_WAIT     = 2'd2;
   localparam logic [CsrAddrW-1:0] CSR_MAX_WAIT         = 2'd3;

   // reset values
   localparam logic [TypeWidth-1:0]  RST_MTU_PACKET_TYPE  = 8'd0;
   localparam logic [CountWidth-1:0] RST_REPEAT_THRESHOLD = 8'd5;
   localparam logic [CfgWaitW-1:0]   RST_INITIAL_WAIT     = 15'd60;
   localparam logic [CfgWaitW-1:0]   RST_MAX_WAIT         = 15'(4 * 60 * 60);

   typedef enum logic [1:0] {
      STATUS_HANDLED    = 2'd0,
      STATUS_WRONG_TYPE = 2'd1,
      STATUS_DROPPED    = 2'd2,
      STATUS_TICK       = 2'd3
   } status_type;

   typedef struct packed {
      logic [TypeWidth-1:0]  mtu_packet_type;
      logic [CountWidth-1:0] repeat_threshold;
      logic [CfgWaitW-1:0]   initial_wait;
      logic [CfgWaitW-1:0]   max_wait;
   } cfg_type;

   typedef struct packed {
      logic [MtuWidth-1:0]   max_seen_mtu;
      logic [CountWidth-1:0] repeat_count;
      logic [WaitWidth-1:0]  tick_counter;
      logic [WaitWidth-1:0]  wait_ticks;
   } state_type;

   typedef struct packed {
      logic                 listening;
      status_type           status;
      logic                 mtu_raised;
      logic [MtuWidth-1:0]  new_max_mtu;
      logic                 converged;
      logic [WaitWidth-1:0] current_wait;
   } result_type;

endpackage

// File: src/pmtu_step.sv
// -----------------------------------------------------------------------------
// Path MTU report convergence: per-transaction update
// Next tracker state and result for one tick or packet, purely combinational.
// -----------------------------------------------------------------------------
module pmtu_step (
   input  pmtu_pkg::cfg_type                    cfg,
   input  pmtu_pkg::state_type                  cur,
   input  logic                                 op,
   input  logic                                 connected,
   input  logic [pmtu_pkg::TypeWidth-1:0]       packet_type,
   input  logic [pmtu_pkg::MtuWidth-1:0]        report_mtu,
   output pmtu_pkg::state_type                  nxt,
   output pmtu_pkg::result_type                 res
);

   logic                                 waiting;
   logic [pmtu_pkg::CountWidth-1:0]      rc_upd;
   logic [pmtu_pkg::MtuWidth-1:0]        max_upd;
   logic [pmtu_pkg::WaitWidth:0]         wait_dbl;
   logic [pmtu_pkg::WaitWidth:0]         wait_cap;
   logic [pmtu_pkg::WaitWidth-1:0]       wait_new;

   assign waiting = cur.tick_counter < cur.wait_ticks;

   always_comb begin
      rc_upd = '0;
      if (report_mtu == cur.max_seen_mtu) begin
         rc_upd = (cur.repeat_count != pmtu_pkg::RepeatMax) ?
                  cur.repeat_count + 1'b1 : cur.repeat_count;
      end
      max_upd = (report_mtu > cur.max_seen_mtu) ? report_mtu : cur.max_seen_mtu;

      // backoff: start at initial wait, then double; past the cap, restart
      wait_dbl = (cur.wait_ticks == '0) ?
                 (pmtu_pkg::WaitWidth+1)'(cfg.initial_wait) : {cur.wait_ticks, 1'b0};
      wait_cap = (pmtu_pkg::WaitWidth+1)'(cfg.max_wait);
      wait_new = (wait_dbl > wait_cap) ?
                 pmtu_pkg::WaitWidth'(cfg.initial_wait) : wait_dbl[pmtu_pkg::WaitWidth-1:0];
   end

   always_comb begin
      nxt            = cur;
      res.status     = pmtu_pkg::STATUS_TICK;
      res.mtu_raised = 1'b0;
      res.converged  = 1'b0;
      if (!connected) begin
         res.status = op ? pmtu_pkg::STATUS_DROPPED : pmtu_pkg::STATUS_TICK;
      end else if (waiting) begin
         if (op) begin
            res.status = pmtu_pkg::STATUS_DROPPED;
         end else begin
            nxt.tick_counter = cur.tick_counter + 1'b1;
         end
      end else if (op) begin
         if (packet_type != cfg.mtu_packet_type) begin
            res.status = pmtu_pkg::STATUS_WRONG_TYPE;
         end else begin
            res.status       = pmtu_pkg::STATUS_HANDLED;
            res.mtu_raised   = report_mtu > cur.max_seen_mtu;
            nxt.repeat_count = rc_upd;
            nxt.max_seen_mtu = max_upd;
            if (rc_upd == cfg.repeat_threshold) begin
               res.converged    = 1'b1;
               nxt.repeat_count = '0;
               nxt.max_seen_mtu = '0;
               nxt.tick_counter = '0;
               nxt.wait_ticks   = wait_new;
            end
         end
      end
      res.listening    = connected && (nxt.tick_counter >= nxt.wait_ticks);
      res.new_max_mtu  = nxt.max_seen_mtu;
      res.current_wait = nxt.wait_ticks;
   end

endmodule

// File: src/path_mtu_report_convergence.sv
// -----------------------------------------------------------------------------
// Path MTU report convergence tracker
// Tracks the largest reported path MTU and backs off once reports converge.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per tick or received packet: req_tuser is the
//   op (0 one-second tick, 1 packet); req_tdata holds connected, packet type
//   and MTU. rsp_* returns exactly one result transaction per request, in order.
//   csr_* writes the four configuration registers; write only while idle.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one transaction per cycle while not stalled; the state update is a
//   single compare/increment/double pass between the state and the result register.
// Reset: synchronous; clears the tracker state, loads register defaults
//   (type 0, threshold 5, initial wait 60, max wait 14400) and empties the
//   result register.
// Stall: with rsp_tready low, the held result stays put and req_tready drops;
//   a request is still taken in the same cycle the held result is drained.
// -----------------------------------------------------------------------------
module path_mtu_report_convergence (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_we,
   input  logic [pmtu_pkg::CsrAddrW-1:0]      csr_addr,
   input  logic [pmtu_pkg::CsrDataW-1:0]      csr_wdata,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // connected, packet_type, mtu
   input  logic                               req_tuser,  // op
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // listening, mtu_raised, new_max_mtu, converged, current_wait
   output logic [39:0]                        rsp_tdata,
   output logic [1:0]                         rsp_tuser   // status
);

   pmtu_pkg::cfg_type    cfg_ff;
   pmtu_pkg::state_type  state_ff;
   pmtu_pkg::state_type  state_in;
   pmtu_pkg::result_type step_res;
   pmtu_pkg::result_type res_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 req_acc;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_acc      = req_tvalid && req_tready;
   assign rsp_valid_in = req_acc || (rsp_valid_ff && !rsp_tready);

   pmtu_step u_step (
      .cfg         (cfg_ff),
      .cur         (state_ff),
      .op          (req_tuser),
      .connected   (req_tdata[0]),
      .packet_type (req_tdata[8:1]),
      .report_mtu  (req_tdata[24:9]),
      .nxt         (state_in),
      .res         (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mtu_packet_type  <= pmtu_pkg::RST_MTU_PACKET_TYPE;
         cfg_ff.repeat_threshold <= pmtu_pkg::RST_REPEAT_THRESHOLD;
         cfg_ff.initial_wait     <= pmtu_pkg::RST_INITIAL_WAIT;
         cfg_ff.max_wait         <= pmtu_pkg::RST_MAX_WAIT;
      end else if (csr_we) begin
         case (csr_addr)
            pmtu_pkg::CSR_MTU_PACKET_TYPE: begin
               cfg_ff.mtu_packet_type <= csr_wdata[pmtu_pkg::TypeWidth-1:0];
            end
            pmtu_pkg::CSR_REPEAT_THRESHOLD: begin
               cfg_ff.repeat_threshold <= csr_wdata[pmtu_pkg::CountWidth-1:0];
            end
            pmtu_pkg::CSR_INITIAL_WAIT: begin
               cfg_ff.initial_wait <= csr_wdata[pmtu_pkg::CfgWaitW-1:0];
            end
            pmtu_pkg::CSR_MAX_WAIT: begin
               cfg_ff.max_wait <= csr_wdata[pmtu_pkg::CfgWaitW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_acc) begin
            state_ff <= state_in;
         end
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      if (req_acc) begin
         res_ff <= step_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = res_ff.status;
   assign rsp_tdata  = {5'd0, res_ff.current_wait, res_ff.converged, res_ff.new_max_mtu,
                        res_ff.mtu_raised, res_ff.listening};

`ifndef SYNTHESIS
   // tick counter never runs past the wait in force
   a_tick_le_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff.tick_counter <= state_ff.wait_ticks)
      else $error("tick counter above wait");

   // the wait only moves on a converging transaction
   a_wait_moves_on_conv: assert property (@(posedge clock)
      !reset && !(req_acc && step_res.converged) |=> $stable(state_ff.wait_ticks))
      else $error("wait changed without convergence");

   // a converged result is a handled packet that cleared tracking
   a_conv_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.converged |->
         res_ff.status == pmtu_pkg::STATUS_HANDLED && res_ff.new_max_mtu == '0)
      else $error("converged result inconsistent");

   // each accepted transaction yields a valid result on the next cycle
   a_result_follows: assert property (@(posedge clock)
      !reset && req_acc |=> rsp_valid_ff)
      else $error("result missing after accept");
`endif

endmodule

// File: tb/path_mtu_report_convergence_tb.sv
// -----------------------------------------------------------------------------
// Path MTU report convergence tracker: self-checking testbench
// Drives ticks and notification packets through the request stream, predicts
// every result transaction with a local model of the tracker and compares it
// field by field. Register settings change between phases, and the phases use
// different mixes of sender gaps and receiver stalls.
// -----------------------------------------------------------------------------
module path_mtu_report_convergence_tb;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_PACKET = 1'b1;
   localparam int   CYCLE_LIMIT = 200000;
   localparam int   LONG_HOLD   = 300;

   typedef struct packed {
      logic                           op;
      logic                           connected;
      logic [pmtu_pkg::TypeWidth-1:0] ptype;
      logic [pmtu_pkg::MtuWidth-1:0]  mtu;
   } pmtu_item_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [pmtu_pkg::CsrAddrW-1:0] csr_addr = '0;
   logic [pmtu_pkg::CsrDataW-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;  // connected, packet_type, mtu
   logic req_tuser = 1'b0;       // op
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   // listening, mtu_raised, new_max_mtu, converged, current_wait
   logic [39:0] rsp_tdata;
   logic [1:0] rsp_tuser;        // status

   path_mtu_report_convergence dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   pmtu_item_type        pending_items[$];
   pmtu_pkg::result_type expected_results[$];
   pmtu_pkg::cfg_type    cfg;
   pmtu_pkg::state_type  tracker_st;   // advanced on accepted transactions
   pmtu_pkg::state_type  plan_st;      // advanced as items are generated
   int         posted_count = 0;
   int         error_count = 0;
   int         cycle_count = 0;
   int         phase_idx = 0;
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;
   int         long_hold_cycles = 0;
   logic       req_taken = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pmtu_pkg::result_type pmtu_predict(inout pmtu_pkg::state_type st,
                                                         input pmtu_pkg::cfg_type c,
                                                         input pmtu_item_type it);
      pmtu_pkg::result_type r;
      logic [16:0] w;
      r = '0;
      r.status = pmtu_pkg::STATUS_TICK;
      if (!it.connected) begin
         r.status = (it.op == OP_PACKET) ? pmtu_pkg::STATUS_DROPPED : pmtu_pkg::STATUS_TICK;
      end else if (st.tick_counter < st.wait_ticks) begin
         if (it.op == OP_PACKET) begin
            r.status = pmtu_pkg::STATUS_DROPPED;
         end else begin
            st.tick_counter = st.tick_counter + 16'd1;
         end
      end else if (it.op == OP_PACKET) begin
         if (it.ptype != c.mtu_packet_type) begin
            r.status = pmtu_pkg::STATUS_WRONG_TYPE;
         end else begin
            r.status = pmtu_pkg::STATUS_HANDLED;
            if (it.mtu == st.max_seen_mtu) begin
               if (st.repeat_count != pmtu_pkg::RepeatMax)
                  st.repeat_count = st.repeat_count + 8'd1;
            end else begin
               st.repeat_count = '0;
            end
            if (it.mtu > st.max_seen_mtu) begin
               st.max_seen_mtu = it.mtu;
               r.mtu_raised = 1'b1;
            end
            if (st.repeat_count == c.repeat_threshold) begin
               r.converged = 1'b1;
               st.repeat_count = '0;
               st.max_seen_mtu = '0;
               st.tick_counter = '0;
               // first backoff loads the initial wait, later ones double
               w = (st.wait_ticks == '0) ? {2'b00, c.initial_wait} : {st.wait_ticks, 1'b0};
               if (w > {2'b00, c.max_wait}) w = {2'b00, c.initial_wait};
               st.wait_ticks = w[15:0];
            end
         end
      end
      r.listening = it.connected && (st.tick_counter >= st.wait_ticks);
      r.new_max_mtu = st.max_seen_mtu;
      r.current_wait = st.wait_ticks;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int exp_v, input int got_v);
      $display("MISMATCH %s: expected %0d got %0d (cycle %0d)", field, exp_v, got_v,
               cycle_count);
      error_count++;
   endtask

   task automatic post_item(input logic op, input logic conn, input logic [7:0] ptype,
                            input logic [15:0] mtu);
      pmtu_item_type it;
      pmtu_pkg::result_type discard;
      it = '{op: op, connected: conn, ptype: ptype, mtu: mtu};
      discard = pmtu_predict(plan_st, cfg, it);
      pending_items.push_back(it);
      posted_count++;
   endtask

   // Mostly well-formed traffic: ticks until the wait is over, then runs of
   // reports that rise and repeat up to the threshold; the rest is noise.
   task automatic gen_traffic(input int n_items, input int tick_cap);
      int stop_at, r, k, reps;
      logic [15:0] v;
      stop_at = posted_count + n_items;
      while (posted_count < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            post_item(1'($urandom), 1'($urandom), 8'($urandom), 16'($urandom));
         end else if (r < 13) begin
            post_item(1'($urandom), 1'b0, cfg.mtu_packet_type, 16'($urandom));
         end else if (plan_st.tick_counter < plan_st.wait_ticks) begin
            k = plan_st.wait_ticks - plan_st.tick_counter;
            if (k > tick_cap) k = $urandom_range(1, tick_cap);
            repeat (k) begin
               if ($urandom_range(0, 19) == 0)
                  post_item(OP_PACKET, 1'b1, cfg.mtu_packet_type, 16'($urandom));
               post_item(OP_TICK, 1'b1, 8'($urandom), 16'($urandom));
            end
         end else begin
            repeat ($urandom_range(0, 3)) begin
               if (plan_st.max_seen_mtu > 16'hF000 || $urandom_range(0, 3) == 0)
                  v = 16'($urandom);
               else
                  v = plan_st.max_seen_mtu + 16'($urandom_range(1, 1500));
               post_item(OP_PACKET, 1'b1, cfg.mtu_packet_type, v);
            end
            reps = cfg.repeat_threshold + $urandom_range(0, 2);
            for (int i = 0; i < reps && plan_st.tick_counter >= plan_st.wait_ticks; i++) begin
               r = $urandom_range(0, 99);
               if (r < 4)
                  post_item(OP_PACKET, 1'b1, cfg.mtu_packet_type ^ 8'($urandom_range(1, 255)),
                            plan_st.max_seen_mtu);
               else if (r < 8)
                  post_item(OP_TICK, 1'b1, 8'($urandom), 16'($urandom));
               else if (r < 11 && reps < 20 && plan_st.max_seen_mtu != '0)
                  post_item(OP_PACKET, 1'b1, cfg.mtu_packet_type,
                            16'($urandom_range(0, plan_st.max_seen_mtu - 1)));
               else
                  post_item(OP_PACKET, 1'b1, cfg.mtu_packet_type, plan_st.max_seen_mtu);
            end
         end
      end
   endtask

   task automatic cfg_write(input logic [pmtu_pkg::CsrAddrW-1:0] idx,
                            input logic [pmtu_pkg::CsrDataW-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      case (idx)
         pmtu_pkg::CSR_MTU_PACKET_TYPE:
            cfg.mtu_packet_type = value[pmtu_pkg::TypeWidth-1:0];
         pmtu_pkg::CSR_REPEAT_THRESHOLD:
            cfg.repeat_threshold = value[pmtu_pkg::CountWidth-1:0];
         pmtu_pkg::CSR_INITIAL_WAIT:     cfg.initial_wait = value;
         pmtu_pkg::CSR_MAX_WAIT:         cfg.max_wait = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // unused upper bits of the narrow registers carry random junk
   task automatic set_phase(input int idx, input logic [7:0] ptype, input logic [7:0] thr,
                            input logic [14:0] init_w, input logic [14:0] max_w,
                            input int send_idle, input int recv_stall);
      wait_drained();
      cfg_write(pmtu_pkg::CSR_MTU_PACKET_TYPE, {7'($urandom), ptype});
      cfg_write(pmtu_pkg::CSR_REPEAT_THRESHOLD, {7'($urandom), thr});
      cfg_write(pmtu_pkg::CSR_INITIAL_WAIT, init_w);
      cfg_write(pmtu_pkg::CSR_MAX_WAIT, max_w);
      sender_idle_pct = send_idle;
      receiver_stall_pct = recv_stall;
      phase_idx = idx;
   endtask

   initial begin
      cfg = '{mtu_packet_type: pmtu_pkg::RST_MTU_PACKET_TYPE,
              repeat_threshold: pmtu_pkg::RST_REPEAT_THRESHOLD,
              initial_wait: pmtu_pkg::RST_INITIAL_WAIT,
              max_wait: pmtu_pkg::RST_MAX_WAIT};
      tracker_st = '0;
      plan_st = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: register defaults, wait still zero so connected means listening
      post_item(OP_TICK, 1'b0, 8'hFF, 16'hFFFF);
      post_item(OP_PACKET, 1'b0, 8'h00, 16'd1500);
      post_item(OP_PACKET, 1'b1, 8'h00, 16'h0000);     // zero report counts as repeat
      post_item(OP_PACKET, 1'b1, 8'hFF, 16'd1500);     // wrong type
      post_item(OP_TICK, 1'b1, 8'h00, 16'h0000);       // tick while listening
      post_item(OP_PACKET, 1'b1, 8'h00, 16'hFFFF);     // raise to the top value
      repeat (5) post_item(OP_PACKET, 1'b1, 8'h00, 16'hFFFF);  // converge
      post_item(OP_PACKET, 1'b1, 8'h00, 16'd9000);     // dropped while waiting
      post_item(OP_TICK, 1'b1, 8'hAA, 16'h5555);
      post_item(OP_TICK, 1'b0, 8'h55, 16'hAAAA);
      gen_traffic(120, 200);

      set_phase(1, 8'hFF, 8'd1, 15'd1, 15'd1, 0, 0);
      gen_traffic(220, 16);
      set_phase(2, 8'hA5, 8'd3, 15'd2, 15'd40, 68, 0);
      gen_traffic(220, 64);
      set_phase(3, 8'h5A, 8'd255, 15'd3, 15'd30, 0, 68);
      gen_traffic(300, 64);

      // threshold zero, zero initial wait, repeat counter saturation
      set_phase(4, 8'h07, 8'd0, 15'd0, 15'd1, 11, 11);
      gen_traffic(200, 64);
      while (plan_st.tick_counter < plan_st.wait_ticks)
         post_item(OP_TICK, 1'b1, 8'($urandom), 16'($urandom));
      repeat (260) post_item(OP_PACKET, 1'b1, cfg.mtu_packet_type, plan_st.max_seen_mtu);

      // initial wait above max wait
      set_phase(5, 8'($urandom), 8'd2, 15'd50, 15'd20, 68, 0);
      gen_traffic(200, 64);
      set_phase(6, 8'($urandom), 8'($urandom_range(1, 8)), 15'($urandom_range(1, 10)),
                15'($urandom_range(1, 64)), 0, 68);
      gen_traffic(200, 64);
      set_phase(7, 8'h80, 8'd4, 15'h7FFF, 15'h7FFF, 11, 11);
      gen_traffic(100, 30);

      wait_drained();
      repeat (16) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   always @(negedge clock) begin : driver
      pmtu_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the offered transaction until it is taken
      end else if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
         nxt = pending_items.pop_front();
         req_tvalid <= 1'b1;
         req_tdata <= {7'd0, nxt.mtu, nxt.ptype, nxt.connected};
         req_tuser <= nxt.op;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (phase_idx == 1 && long_hold_cycles < LONG_HOLD) begin
         // long back-pressure while the sender keeps offering
         rsp_tready <= 1'b0;
         long_hold_cycles <= long_hold_cycles + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      pmtu_item_type it;
      pmtu_pkg::result_type want, got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            it.op = req_tuser;
            it.connected = req_tdata[0];
            it.ptype = req_tdata[8:1];
            it.mtu = req_tdata[24:9];
            expected_results.push_back(pmtu_predict(tracker_st, cfg, it));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.listening = rsp_tdata[0];
            got.mtu_raised = rsp_tdata[1];
            got.new_max_mtu = rsp_tdata[17:2];
            got.converged = rsp_tdata[18];
            got.current_wait = rsp_tdata[34:19];
            got.status = pmtu_pkg::status_type'(rsp_tuser);
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result transaction", 0, 1);
            end else begin
               want = expected_results.pop_front();
               if (got.listening !== want.listening)
                  report_mismatch("listening", want.listening, got.listening);
               if (got.status !== want.status)
                  report_mismatch("status", want.status, got.status);
               if (got.mtu_raised !== want.mtu_raised)
                  report_mismatch("mtu_raised", want.mtu_raised, got.mtu_raised);
               if (got.new_max_mtu !== want.new_max_mtu)
                  report_mismatch("new_max_mtu", want.new_max_mtu, got.new_max_mtu);
               if (got.converged !== want.converged)
                  report_mismatch("converged", want.converged, got.converged);
               if (got.current_wait !== want.current_wait)
                  report_mismatch("current_wait", want.current_wait, got.current_wait);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
